/* rtl/core/ddpi_pkg.sv */
package ddpi_pkg;

    // Configuration register indexes.
    typedef enum logic [2:0] {
        CFG_WHEEL_BASE    = 3'd0,
        CFG_TIME_STEP     = 3'd1,
        CFG_START_X       = 3'd2,
        CFG_START_Y       = 3'd3,
        CFG_START_HEADING = 3'd4
    } cfg_idx_t;

    typedef struct packed {
        logic signed [15:0] left_speed;
        logic signed [15:0] right_speed;
        logic               reload;
    } tick_item_t;

    typedef struct packed {
        logic signed [31:0] pos_x;
        logic signed [31:0] pos_y;
        logic        [15:0] heading;
        logic signed [15:0] speed;
        logic signed [15:0] turn_rate;
    } pose_item_t;

    typedef struct packed {
        cfg_idx_t    index;
        logic [31:0] data;
    } cfg_item_t;

    // Operand selection for the shared 33 x 17 bit multiplier.
    typedef enum logic [3:0] {
        MUL_NONE,
        MUL_SPD_TS,
        MUL_OMG_TS,
        MUL_COS_HI,
        MUL_COS_LO,
        MUL_SIN_HI,
        MUL_SIN_LO,
        MUL_K_HI,
        MUL_K_LO
    } mul_op_t;

    // What happens to the registered product.
    typedef enum logic [2:0] {
        ACC_NONE,
        ACC_SAVE_ST,
        ACC_SAVE_OT,
        ACC_LOAD_HI,
        ACC_ADD
    } acc_op_t;

    typedef enum logic [3:0] {
        S_IDLE,
        S_WAIT,
        S_MUL_ST,
        S_MUL_OT,
        S_MUL_XH,
        S_MUL_XL,
        S_MUL_YH,
        S_MUL_YL,
        S_MUL_HH,
        S_MUL_HL,
        S_HEAD,
        S_FINISH
    } state_t;

    typedef struct packed {
        logic    load;
        mul_op_t mul_op;
        acc_op_t acc_op;
        logic    commit_x;
        logic    commit_y;
        logic    finish;
    } ddpi_cmd_t;

    typedef struct packed {
        logic cordic_idle;
        logic div_idle;
    } ddpi_status_t;

    localparam logic signed [32:0] CORDIC_X0     = 33'sd652032874;
    localparam logic        [31:0] QUAD_BIAS     = 32'h2000_0000;
    localparam logic        [31:0] RAD_TO_TURN32 = 32'd683565276;
    localparam logic signed [16:0] K_HI          = {1'b0, RAD_TO_TURN32[31:16]};
    localparam logic signed [16:0] K_LO          = {1'b0, RAD_TO_TURN32[15:0]};
    localparam int                 POS_SHIFT     = 38;
    localparam int                 DIV_STEPS     = 24;
    localparam int                 DIV_CNT_W     = 5;

    // Arctangent of 2^-i in units of 2^-32 turn.
    function automatic logic [31:0] atan_turn(input logic [4:0] i);
        logic [31:0] v;
        begin
            unique case (i)
                5'd0:    v = 32'h2000_0000;
                5'd1:    v = 32'h12E4_051E;
                5'd2:    v = 32'h09FB_385B;
                5'd3:    v = 32'h0511_11D4;
                5'd4:    v = 32'h028B_0D43;
                5'd5:    v = 32'h0145_D7E1;
                5'd6:    v = 32'h00A2_F61E;
                5'd7:    v = 32'h0051_7C55;
                5'd8:    v = 32'h0028_BE53;
                5'd9:    v = 32'h0014_5F2F;
                5'd10:   v = 32'h000A_2F98;
                5'd11:   v = 32'h0005_17CC;
                5'd12:   v = 32'h0002_8BE6;
                5'd13:   v = 32'h0001_45F3;
                5'd14:   v = 32'h0000_A2FA;
                5'd15:   v = 32'h0000_517D;
                5'd16:   v = 32'h0000_28BE;
                5'd17:   v = 32'h0000_145F;
                5'd18:   v = 32'h0000_0A30;
                5'd19:   v = 32'h0000_0518;
                5'd20:   v = 32'h0000_028C;
                5'd21:   v = 32'h0000_0146;
                5'd22:   v = 32'h0000_00A3;
                5'd23:   v = 32'h0000_0051;
                default: v = 32'h0000_0000;
            endcase
            return v;
        end
    endfunction

endpackage

/* rtl/core/ddpi_chan_if.sv */
interface ddpi_tick_if;
    import ddpi_pkg::*;
    logic       valid;
    logic       ready;
    tick_item_t payload;
    modport source (output valid, output payload, input ready);
    modport sink (input valid, input payload, output ready);
endinterface

interface ddpi_pose_if;
    import ddpi_pkg::*;
    logic       valid;
    logic       ready;
    pose_item_t payload;
    modport source (output valid, output payload, input ready);
    modport sink (input valid, input payload, output ready);
endinterface

interface ddpi_cfg_if;
    import ddpi_pkg::*;
    logic      valid;
    logic      ready;
    cfg_item_t payload;
    modport source (output valid, output payload, input ready);
    modport sink (input valid, input payload, output ready);
endinterface

/* rtl/core/diff_drive_pose_integrator_core.sv */
// Differential-drive pose integrator, forward Euler odometry in fixed point.
// The tick channel carries one transfer per time step: left and right wheel
// speeds (Q8.8) and a reload flag. Each tick produces exactly one transfer on
// the pose channel: x and y (Q16.16, saturated), the heading as a 16-bit
// binary angle, the centre speed and the turn rate (Q8.8, saturated).
// The cfg channel writes wheel_base, time_step, start_x, start_y and
// start_heading by index 0 to 4; other indexes are ignored. It is always
// ready and must only be used while no tick is in flight.
// The 24-step restoring divider that forms the turn rate sets the time from
// an accepted tick to its pose transfer; the CORDIC runs beside it, and the
// multiply steps on the shared multiplier follow. One tick is in work at a
// time: the next tick is accepted only once the last has written its result
// to the output register.
// Reset returns the pose to the origin with heading zero, loads wheel_base
// 128 and time_step 6554, and empties the output register. A stalled pose
// receiver holds its result in the output register while the next tick is
// already accepted and worked on; that tick waits at its end for the slot.
module diff_drive_pose_integrator_core #(
    parameter int ANGLE_BITS      = 16,
    parameter int TRIG_ITERATIONS = 16
) (
    input  logic              clk,
    input  logic              rst_n,
    ddpi_tick_if.sink         tick,
    ddpi_pose_if.source       pose,
    ddpi_cfg_if.sink          cfg
);
    import ddpi_pkg::*;

    ddpi_cmd_t    cmd;
    ddpi_status_t status;
    logic         cfg_we;

    // The cfg channel is always ready, so every register write is accepted.
    assign cfg.ready = 1'b1;
    assign cfg_we    = cfg.valid && cfg.ready;

    // The controller sequences the divider, CORDIC and multiply steps.
    ddpi_ctrl u_ctrl (
        .clk        (clk),
        .rst_n      (rst_n),
        .tick_valid (tick.valid),
        .tick_ready (tick.ready),
        .pose_valid (pose.valid),
        .pose_ready (pose.ready),
        .status     (status),
        .cmd        (cmd)
    );

    // The datapath holds configuration, pose state and the output register.
    ddpi_dpath #(
        .ANGLE_BITS      (ANGLE_BITS),
        .TRIG_ITERATIONS (TRIG_ITERATIONS)
    ) u_dpath (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .status    (status),
        .tick_item (tick.payload),
        .cfg_we    (cfg_we),
        .cfg_item  (cfg.payload),
        .pose_item (pose.payload)
    );

    // Starting an item puts both iterative units to work.
    a_units_start: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.load |=> !status.div_idle && !status.cordic_idle)
        else $error("iterative units did not start on an accepted tick");

    // The result is only written once both units have finished.
    a_finish_idle: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.finish |-> status.div_idle && status.cordic_idle)
        else $error("result written while a unit is still busy");

    // A finished item is presented on the pose channel in the next cycle.
    a_finish_valid: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.finish |=> pose.valid)
        else $error("finished result not presented");

    // Only one tick is in work at a time.
    a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
        tick.valid && tick.ready |=> !tick.ready)
        else $error("second tick accepted while one is in work");

endmodule

/* rtl/core/ddpi_cordic.sv */
module ddpi_cordic #(
    parameter int TRIG_ITERATIONS = 16
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    input  logic        [31:0] turn,
    output logic signed [32:0] cos_val,
    output logic signed [32:0] sin_val,
    output logic               idle
);
    import ddpi_pkg::*;

    localparam int ITER_W = $clog2(TRIG_ITERATIONS);

    logic                busy_reg, busy_next;
    logic [ITER_W-1:0]   iter_reg, iter_next;
    logic signed [32:0]  x_reg, x_next;
    logic signed [32:0]  y_reg, y_next;
    logic signed [32:0]  z_reg, z_next;
    logic [1:0]          q_reg, q_next;

    logic [31:0]         biased;
    logic [1:0]          q_in;
    logic [31:0]         z_in;
    logic signed [32:0]  x_sh, y_sh, step_angle;

    // The angle is folded to the nearest quadrant; the residual is rotated.
    assign biased     = turn + QUAD_BIAS;
    assign q_in       = biased[31:30];
    assign z_in       = turn - {q_in, 30'd0};
    assign x_sh       = x_reg >>> iter_reg;
    assign y_sh       = y_reg >>> iter_reg;
    assign step_angle = {1'b0, atan_turn(5'(iter_reg))};

    always_comb
    begin
        busy_next = busy_reg;
        iter_next = iter_reg;
        x_next    = x_reg;
        y_next    = y_reg;
        z_next    = z_reg;
        q_next    = q_reg;
        if (start)
        begin
            busy_next = 1'b1;
            iter_next = '0;
            x_next    = CORDIC_X0;
            y_next    = '0;
            z_next    = {z_in[31], z_in};
            q_next    = q_in;
        end
        else if (busy_reg)
        begin
            if (!z_reg[32])
            begin
                x_next = x_reg - y_sh;
                y_next = y_reg + x_sh;
                z_next = z_reg - step_angle;
            end
            else
            begin
                x_next = x_reg + y_sh;
                y_next = y_reg - x_sh;
                z_next = z_reg + step_angle;
            end
            iter_next = iter_reg + 1'b1;
            if (iter_reg == ITER_W'(TRIG_ITERATIONS - 1))
            begin
                busy_next = 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            iter_reg <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            iter_reg <= iter_next;
        end
    end

    always_ff @(posedge clk)
    begin
        x_reg <= x_next;
        y_reg <= y_next;
        z_reg <= z_next;
        q_reg <= q_next;
    end

    // Undo the quadrant fold.
    always_comb
    begin
        unique case (q_reg)
            2'd0:
            begin
                cos_val = x_reg;
                sin_val = y_reg;
            end
            2'd1:
            begin
                cos_val = -y_reg;
                sin_val = x_reg;
            end
            2'd2:
            begin
                cos_val = -x_reg;
                sin_val = -y_reg;
            end
            default:
            begin
                cos_val = y_reg;
                sin_val = -x_reg;
            end
        endcase
    end

    assign idle = !busy_reg;

endmodule

/* rtl/core/ddpi_div.sv */
module ddpi_div (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    input  logic signed [16:0] diff,
    input  logic        [15:0] divisor,
    output logic signed [15:0] omega,
    output logic               idle
);
    import ddpi_pkg::*;

    logic                 busy_reg, busy_next;
    logic [DIV_CNT_W-1:0] cnt_reg, cnt_next;
    logic [15:0]          rem_reg, rem_next;
    logic [23:0]          quo_reg, quo_next;
    logic                 neg_reg, neg_next;
    logic                 nz_reg, nz_next;

    logic [16:0]          mag;
    logic [16:0]          trial;
    logic [16:0]          trial_sub;
    logic                 ge;

    assign mag       = diff[16] ? -diff : diff;
    assign trial     = {rem_reg, quo_reg[23]};
    assign trial_sub = trial - {1'b0, divisor};
    assign ge        = trial >= {1'b0, divisor};

    // Restoring division of |diff| * 256 by the wheel base, one bit per cycle.
    always_comb
    begin
        busy_next = busy_reg;
        cnt_next  = cnt_reg;
        rem_next  = rem_reg;
        quo_next  = quo_reg;
        neg_next  = neg_reg;
        nz_next   = nz_reg;
        if (start)
        begin
            busy_next = 1'b1;
            cnt_next  = '0;
            rem_next  = '0;
            quo_next  = {mag[15:0], 8'd0};
            neg_next  = diff[16];
            nz_next   = (diff != '0);
        end
        else if (busy_reg)
        begin
            rem_next = ge ? trial_sub[15:0] : trial[15:0];
            quo_next = {quo_reg[22:0], ge};
            cnt_next = cnt_reg + 1'b1;
            if (cnt_reg == DIV_CNT_W'(DIV_STEPS - 1))
            begin
                busy_next = 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        quo_reg <= quo_next;
        neg_reg <= neg_next;
        nz_reg  <= nz_next;
    end

    // Sign, saturation, and the zero wheel base case.
    always_comb
    begin
        priority if (divisor == '0)
        begin
            omega = !nz_reg ? 16'sd0 : (neg_reg ? 16'sh8000 : 16'sh7FFF);
        end
        else if (neg_reg)
        begin
            omega = (quo_reg > 24'd32768) ? 16'sh8000 : -quo_reg[15:0];
        end
        else
        begin
            omega = (quo_reg > 24'd32767) ? 16'sh7FFF : quo_reg[15:0];
        end
    end

    assign idle = !busy_reg;

endmodule

/* rtl/core/ddpi_ctrl.sv */
module ddpi_ctrl (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  tick_valid,
    output logic                  tick_ready,
    output logic                  pose_valid,
    input  logic                  pose_ready,
    input  ddpi_pkg::ddpi_status_t status,
    output ddpi_pkg::ddpi_cmd_t   cmd
);
    import ddpi_pkg::*;

    state_t state_reg, state_next;
    logic   out_valid_reg, out_valid_next;
    logic   out_free;

    assign out_free = !out_valid_reg || pose_ready;

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:   if (tick_valid) state_next = S_WAIT;
            S_WAIT:   if (status.cordic_idle && status.div_idle) state_next = S_MUL_ST;
            S_MUL_ST: state_next = S_MUL_OT;
            S_MUL_OT: state_next = S_MUL_XH;
            S_MUL_XH: state_next = S_MUL_XL;
            S_MUL_XL: state_next = S_MUL_YH;
            S_MUL_YH: state_next = S_MUL_YL;
            S_MUL_YL: state_next = S_MUL_HH;
            S_MUL_HH: state_next = S_MUL_HL;
            S_MUL_HL: state_next = S_HEAD;
            S_HEAD:   state_next = S_FINISH;
            S_FINISH: if (out_free) state_next = S_IDLE;
            default:  state_next = S_IDLE;
        endcase
    end

    always_comb
    begin
        tick_ready   = 1'b0;
        cmd          = '0;
        cmd.mul_op   = MUL_NONE;
        cmd.acc_op   = ACC_NONE;
        unique case (state_reg)
            S_IDLE:
            begin
                tick_ready = 1'b1;
                cmd.load   = tick_valid;
            end
            S_WAIT:
            begin
            end
            S_MUL_ST:
            begin
                cmd.mul_op = MUL_SPD_TS;
            end
            S_MUL_OT:
            begin
                cmd.mul_op = MUL_OMG_TS;
                cmd.acc_op = ACC_SAVE_ST;
            end
            S_MUL_XH:
            begin
                cmd.mul_op = MUL_COS_HI;
                cmd.acc_op = ACC_SAVE_OT;
            end
            S_MUL_XL:
            begin
                cmd.mul_op = MUL_COS_LO;
                cmd.acc_op = ACC_LOAD_HI;
            end
            S_MUL_YH:
            begin
                cmd.mul_op = MUL_SIN_HI;
                cmd.acc_op = ACC_ADD;
            end
            S_MUL_YL:
            begin
                cmd.mul_op   = MUL_SIN_LO;
                cmd.acc_op   = ACC_LOAD_HI;
                cmd.commit_x = 1'b1;
            end
            S_MUL_HH:
            begin
                cmd.mul_op = MUL_K_HI;
                cmd.acc_op = ACC_ADD;
            end
            S_MUL_HL:
            begin
                cmd.mul_op   = MUL_K_LO;
                cmd.acc_op   = ACC_LOAD_HI;
                cmd.commit_y = 1'b1;
            end
            S_HEAD:
            begin
                cmd.acc_op = ACC_ADD;
            end
            S_FINISH:
            begin
                cmd.finish = out_free;
            end
            default:
            begin
            end
        endcase
    end

    assign out_valid_next = cmd.finish || (out_valid_reg && !pose_ready);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign pose_valid = out_valid_reg;

endmodule

/* rtl/core/ddpi_dpath.sv */
module ddpi_dpath #(
    parameter int ANGLE_BITS      = 16,
    parameter int TRIG_ITERATIONS = 16
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  ddpi_pkg::ddpi_cmd_t   cmd,
    output ddpi_pkg::ddpi_status_t status,
    input  ddpi_pkg::tick_item_t  tick_item,
    input  logic                  cfg_we,
    input  ddpi_pkg::cfg_item_t   cfg_item,
    output ddpi_pkg::pose_item_t  pose_item
);
    import ddpi_pkg::*;

    localparam int                 HEAD_SHIFT = 56 - ANGLE_BITS;
    localparam int                 TURN_PAD   = 32 - ANGLE_BITS;
    localparam logic signed [63:0] POS_RND    = 64'sd1 <<< (POS_SHIFT - 1);
    localparam logic signed [63:0] HEAD_RND   = 64'sd1 <<< (HEAD_SHIFT - 1);

    // Configuration.
    logic        [15:0]     wheel_base_reg;
    logic        [15:0]     time_step_reg;
    logic signed [31:0]     start_x_reg;
    logic signed [31:0]     start_y_reg;
    logic        [15:0]     start_heading_reg;

    // Pose state.
    logic signed [31:0]     pose_x_reg, pose_y_reg;
    logic [ANGLE_BITS-1:0]  pose_h_reg;

    // Item and arithmetic registers.
    logic signed [15:0]     spd_reg;
    logic                   reload_reg;
    logic signed [32:0]     pst_reg, pot_reg;
    logic signed [49:0]     prod_reg;
    logic signed [63:0]     acc_reg;
    pose_item_t             out_reg;

    logic [16:0]            sum_in;
    logic signed [16:0]     diff_in;
    logic signed [32:0]     cos_val, sin_val;
    logic signed [15:0]     omega;
    logic signed [32:0]     mul_a;
    logic signed [16:0]     mul_b;
    logic signed [49:0]     prod_next;
    logic [63:0]            prod_ext;
    logic signed [63:0]     pos_rnd, head_rnd;
    logic signed [25:0]     dpos;
    logic signed [31:0]     pos_base;
    logic signed [33:0]     pos_sum;
    logic signed [31:0]     pos_sat;
    logic [ANGLE_BITS-1:0]  h_step, h_start, h_final;
    logic [15:0]            h_out;
    pose_item_t             out_next;

    assign sum_in  = {tick_item.left_speed[15], tick_item.left_speed}
                   + {tick_item.right_speed[15], tick_item.right_speed};
    assign diff_in = {tick_item.right_speed[15], tick_item.right_speed}
                   - {tick_item.left_speed[15], tick_item.left_speed};

    ddpi_cordic #(
        .TRIG_ITERATIONS(TRIG_ITERATIONS)
    ) u_cordic (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (cmd.load),
        .turn    ({pose_h_reg, {TURN_PAD{1'b0}}}),
        .cos_val (cos_val),
        .sin_val (sin_val),
        .idle    (status.cordic_idle)
    );

    ddpi_div u_div (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (cmd.load),
        .diff    (diff_in),
        .divisor (wheel_base_reg),
        .omega   (omega),
        .idle    (status.div_idle)
    );

    // Shared multiplier; wide products are built from a high and a low half.
    always_comb
    begin
        unique case (cmd.mul_op)
            MUL_SPD_TS:
            begin
                mul_a = {{17{spd_reg[15]}}, spd_reg};
                mul_b = {1'b0, time_step_reg};
            end
            MUL_OMG_TS:
            begin
                mul_a = {{17{omega[15]}}, omega};
                mul_b = {1'b0, time_step_reg};
            end
            MUL_COS_HI:
            begin
                mul_a = pst_reg;
                mul_b = cos_val[32:16];
            end
            MUL_COS_LO:
            begin
                mul_a = pst_reg;
                mul_b = {1'b0, cos_val[15:0]};
            end
            MUL_SIN_HI:
            begin
                mul_a = pst_reg;
                mul_b = sin_val[32:16];
            end
            MUL_SIN_LO:
            begin
                mul_a = pst_reg;
                mul_b = {1'b0, sin_val[15:0]};
            end
            MUL_K_HI:
            begin
                mul_a = pot_reg;
                mul_b = K_HI;
            end
            MUL_K_LO:
            begin
                mul_a = pot_reg;
                mul_b = K_LO;
            end
            default:
            begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    assign prod_next = mul_a * mul_b;
    assign prod_ext  = {{14{prod_reg[49]}}, prod_reg};

    // Position step: round half up, then add and saturate to 32 bits.
    assign pos_rnd  = acc_reg + POS_RND;
    assign dpos     = pos_rnd[63:POS_SHIFT];
    assign pos_base = cmd.commit_x ? pose_x_reg : pose_y_reg;
    assign pos_sum  = {{2{pos_base[31]}}, pos_base} + {{8{dpos[25]}}, dpos};

    always_comb
    begin
        if (pos_sum[33:31] == 3'b000 || pos_sum[33:31] == 3'b111)
        begin
            pos_sat = pos_sum[31:0];
        end
        else
        begin
            pos_sat = pos_sum[33] ? 32'sh8000_0000 : 32'sh7FFF_FFFF;
        end
    end

    // Heading step wraps at the angle width.
    assign head_rnd = acc_reg + HEAD_RND;
    assign h_step   = head_rnd[HEAD_SHIFT +: ANGLE_BITS];
    assign h_final  = reload_reg ? h_start : pose_h_reg + h_step;

    generate
        if (ANGLE_BITS >= 16)
        begin : g_wide_angle
            assign h_start = ANGLE_BITS'(start_heading_reg) << (ANGLE_BITS - 16);
            assign h_out   = 16'(h_final >> (ANGLE_BITS - 16));
        end
        else
        begin : g_narrow_angle
            assign h_start = start_heading_reg[15 -: ANGLE_BITS];
            assign h_out   = 16'(h_final) << (16 - ANGLE_BITS);
        end
    endgenerate

    always_comb
    begin
        out_next.pos_x     = pose_x_reg;
        out_next.pos_y     = pose_y_reg;
        out_next.heading   = h_out;
        out_next.speed     = spd_reg;
        out_next.turn_rate = omega;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wheel_base_reg    <= 16'd128;
            time_step_reg     <= 16'd6554;
            start_x_reg       <= '0;
            start_y_reg       <= '0;
            start_heading_reg <= '0;
            pose_x_reg        <= '0;
            pose_y_reg        <= '0;
            pose_h_reg        <= '0;
        end
        else
        begin
            if (cfg_we)
            begin
                unique case (cfg_item.index)
                    CFG_WHEEL_BASE:    wheel_base_reg    <= cfg_item.data[15:0];
                    CFG_TIME_STEP:     time_step_reg     <= cfg_item.data[15:0];
                    CFG_START_X:       start_x_reg       <= cfg_item.data;
                    CFG_START_Y:       start_y_reg       <= cfg_item.data;
                    CFG_START_HEADING: start_heading_reg <= cfg_item.data[15:0];
                    default:
                    begin
                    end
                endcase
            end
            if (cmd.commit_x)
            begin
                pose_x_reg <= reload_reg ? start_x_reg : pos_sat;
            end
            if (cmd.commit_y)
            begin
                pose_y_reg <= reload_reg ? start_y_reg : pos_sat;
            end
            if (cmd.finish)
            begin
                pose_h_reg <= h_final;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            spd_reg    <= sum_in[16:1];
            reload_reg <= tick_item.reload;
        end
        prod_reg <= prod_next;
        unique case (cmd.acc_op)
            ACC_SAVE_ST: pst_reg <= prod_reg[32:0];
            ACC_SAVE_OT: pot_reg <= prod_reg[32:0];
            ACC_LOAD_HI: acc_reg <= prod_ext << 16;
            ACC_ADD:     acc_reg <= acc_reg + prod_ext;
            default:
            begin
            end
        endcase
        if (cmd.finish)
        begin
            out_reg <= out_next;
        end
    end

    assign pose_item = out_reg;

endmodule
